### sv/pfla_pkg.sv
`default_nettype none

package pfla_pkg;

  // Action codes carried by in_action.
  typedef enum logic [2:0] {
    ACT_ALLOC_LOW  = 3'd0,
    ACT_FREE_LOW   = 3'd1,
    ACT_ALLOC_HIGH = 3'd2,
    ACT_FREE_HIGH  = 3'd3,
    ACT_SET_LIMIT  = 3'd4
  } act_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_LOW_BASE  = 2'd0;
  localparam logic [1:0] CFG_HIGH_BASE = 2'd1;
  localparam logic [1:0] CFG_INIT_LIM  = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [15:0] LOW_BASE_RST  = 16'd256;
  localparam logic [15:0] HIGH_BASE_RST = 16'd4352;
  localparam logic [15:0] INIT_LIM_RST  = 16'hFFFF;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_POP  = 1'b1
  } state_t;

  // Events sent to the budget unit for one item or one register write.
  typedef struct packed {
    logic        cfg_load;    // initial limit written
    logic        high_alloc;  // high allocation seen
    logic        high_take;   // high allocation granted a page
    logic        high_free;   // high free accepted
    logic        set_limit;   // set limit action
    logic [15:0] value;       // limit value or register data
  } bud_cmd_t;

  typedef struct packed {
    logic exceeded;      // current sticky flag
    logic budget_zero;   // no budget left
    logic exceeded_nxt;  // flag after the current event
  } bud_stat_t;

endpackage

`default_nettype wire

### sv/pfla_next_ram.sv
`default_nettype none

module pfla_next_ram
  import pfla_pkg::*;
#(
  parameter int PAGE_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [PAGE_BITS-1:0] waddr,
  input  wire logic [PAGE_BITS-1:0] wdata,
  input  wire logic                 re,
  input  wire logic [PAGE_BITS-1:0] raddr,
  output logic      [PAGE_BITS-1:0] rdata
);

  localparam int Depth = 1 << PAGE_BITS;

  logic [PAGE_BITS-1:0] mem [Depth];
  logic [PAGE_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### sv/pfla_budget.sv
`default_nettype none

module pfla_budget
  import pfla_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire bud_cmd_t  cmd,
  output bud_stat_t      stat
);

  logic [15:0] budget_r, budget_nxt;
  logic [15:0] base_r, base_nxt;
  logic        exceeded_r, exceeded_nxt;
  logic [15:0] used;
  logic [17:0] rebased;

  // Budget left minus the previous limit plus the new one; only looked at
  // when it cannot go negative.
  assign used    = base_r - budget_r;
  assign rebased = {2'b00, budget_r} + {2'b00, cmd.value} - {2'b00, base_r};

  always_comb begin
    budget_nxt   = budget_r;
    base_nxt     = base_r;
    exceeded_nxt = exceeded_r;
    if (cmd.cfg_load) begin
      budget_nxt   = cmd.value;
      base_nxt     = cmd.value;
      exceeded_nxt = 1'b0;
    end else if (cmd.high_alloc) begin
      if (!exceeded_r && budget_r == 16'd0) begin
        exceeded_nxt = 1'b1;
      end
      if (cmd.high_take) begin
        budget_nxt = budget_r - 16'd1;
      end
    end else if (cmd.high_free) begin
      if (budget_r != 16'hFFFF) begin
        budget_nxt = budget_r + 16'd1;
      end
    end else if (cmd.set_limit) begin
      if (!exceeded_r) begin
        if (budget_r < base_r && used > cmd.value) begin
          exceeded_nxt = 1'b1;
        end else if (rebased[17:16] != 2'b00) begin
          budget_nxt = 16'hFFFF;
        end else begin
          budget_nxt = rebased[15:0];
        end
      end
      base_nxt = cmd.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r   <= INIT_LIM_RST;
      base_r     <= INIT_LIM_RST;
      exceeded_r <= 1'b0;
    end else begin
      budget_r   <= budget_nxt;
      base_r     <= base_nxt;
      exceeded_r <= exceeded_nxt;
    end
  end

  assign stat.exceeded     = exceeded_r;
  assign stat.budget_zero  = (budget_r == 16'd0);
  assign stat.exceeded_nxt = exceeded_nxt;

endmodule

`default_nettype wire

### sv/page_free_list_allocator.sv
`default_nettype none

// Two-region page allocator. Each region (low and high) hands out pages from
// a free list when it holds any, and otherwise from a bump pointer that
// starts at the region's base page and stops below the top page of page
// space (an allocation there reports out_of_pages with granted page zero).
// Freed pages are pushed onto their region's list; the links live in a
// single-port-write, registered-read memory of 2^PAGE_BITS entries indexed by
// page number, which is not cleared after reset and needs no clearing pass.
// High allocations draw down a budget; an allocation at zero budget sets a
// sticky limit_exceeded flag, after which high allocations return the bump
// page without changing anything and high frees are ignored. Every item
// gives exactly one result item. An allocation that pops a free list goes
// through the pop state, because the new list head comes back from the link
// memory's registered read data; every other item is answered from idle. The
// next item is taken once the block is idle and the output register is free
// or being emptied. Writing a base register reloads that region's bump
// pointer; writing the initial limit reloads the budget and clears the flag.
// Registers are written only while the block is idle: cfg_ready is high only
// outside a pop, and an input item waits while a register write is offered.
module page_free_list_allocator
  import pfla_pkg::*;
#(
  parameter int PAGE_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration write channel.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  // Input items.
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_action,
  input  wire logic [15:0] in_page_number,
  input  wire logic [15:0] in_limit_value,
  // Result items.
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_granted_page,
  output logic             out_limit_exceeded,
  output logic             out_out_of_pages
);

  localparam logic [PAGE_BITS-1:0] PMAX     = '1;
  localparam logic [PAGE_BITS-1:0] PZERO    = '0;
  localparam logic [PAGE_BITS-1:0] PONE     = PAGE_BITS'(1);
  localparam logic [PAGE_BITS-1:0] LOW_RST  = PAGE_BITS'(LOW_BASE_RST);
  localparam logic [PAGE_BITS-1:0] HIGH_RST = PAGE_BITS'(HIGH_BASE_RST);

  state_t state_r, state_nxt;

  logic [PAGE_BITS-1:0] low_bump_r, low_bump_nxt;
  logic [PAGE_BITS-1:0] high_bump_r, high_bump_nxt;
  logic [PAGE_BITS-1:0] low_head_r, low_head_nxt;
  logic [PAGE_BITS-1:0] high_head_r, high_head_nxt;
  logic [PAGE_BITS-1:0] pop_page_r, pop_page_nxt;
  logic                 pop_high_r, pop_high_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_page_r, out_page_nxt;
  logic        out_exc_r, out_exc_nxt;
  logic        out_oop_r, out_oop_nxt;

  logic                 in_fire;
  logic                 cfg_fire;
  logic                 out_free;
  logic [PAGE_BITS-1:0] page_m;
  logic [PAGE_BITS-1:0] cfg_page;

  logic                 ram_we;
  logic [PAGE_BITS-1:0] ram_waddr;
  logic [PAGE_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [PAGE_BITS-1:0] ram_raddr;
  logic [PAGE_BITS-1:0] ram_rdata;

  bud_cmd_t  bud_cmd;
  bud_stat_t bud_stat;

  assign cfg_ready = (state_r == ST_IDLE);
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && out_free && !cfg_valid;
  assign in_fire   = in_valid && in_ready;
  assign page_m    = PAGE_BITS'(in_page_number);
  assign cfg_page  = PAGE_BITS'(cfg_data);

  // Apply register writes, decode the item, update heads and bump pointers,
  // and drive the link memory. A pop only issues the read here; the head is
  // replaced in the following cycle from the memory's read data.
  always_comb begin
    state_nxt     = state_r;
    low_bump_nxt  = low_bump_r;
    high_bump_nxt = high_bump_r;
    low_head_nxt  = low_head_r;
    high_head_nxt = high_head_r;
    pop_page_nxt  = pop_page_r;
    pop_high_nxt  = pop_high_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_page_nxt  = out_page_r;
    out_exc_nxt   = out_exc_r;
    out_oop_nxt   = out_oop_r;
    ram_we        = 1'b0;
    ram_waddr     = page_m;
    ram_wdata     = low_head_r;
    ram_re        = 1'b0;
    ram_raddr     = low_head_r;
    bud_cmd       = '0;
    bud_cmd.value = in_limit_value;

    case (state_r)
      ST_IDLE: begin
        if (cfg_fire) begin
          bud_cmd.value = cfg_data;
          case (cfg_index)
            CFG_LOW_BASE:  low_bump_nxt     = cfg_page;
            CFG_HIGH_BASE: high_bump_nxt    = cfg_page;
            CFG_INIT_LIM:  bud_cmd.cfg_load = 1'b1;
            default: ;
          endcase
        end else if (in_fire) begin
          out_valid_nxt = 1'b1;
          out_page_nxt  = 16'd0;
          out_oop_nxt   = 1'b0;
          case (in_action)
            ACT_ALLOC_LOW: begin
              if (low_head_r != PZERO) begin
                ram_re        = 1'b1;
                ram_raddr     = low_head_r;
                pop_page_nxt  = low_head_r;
                pop_high_nxt  = 1'b0;
                out_valid_nxt = 1'b0;
                state_nxt     = ST_POP;
              end else if (low_bump_r == PMAX) begin
                out_oop_nxt = 1'b1;
              end else begin
                out_page_nxt = 16'(low_bump_r);
                low_bump_nxt = low_bump_r + PONE;
              end
            end
            ACT_FREE_LOW: begin
              if (page_m != PZERO) begin
                ram_we       = 1'b1;
                ram_waddr    = page_m;
                ram_wdata    = low_head_r;
                low_head_nxt = page_m;
              end
            end
            ACT_ALLOC_HIGH: begin
              bud_cmd.high_alloc = 1'b1;
              if (bud_stat.exceeded || bud_stat.budget_zero) begin
                out_page_nxt = 16'(high_bump_r);
              end else if (high_head_r != PZERO) begin
                bud_cmd.high_take = 1'b1;
                ram_re            = 1'b1;
                ram_raddr         = high_head_r;
                pop_page_nxt      = high_head_r;
                pop_high_nxt      = 1'b1;
                out_valid_nxt     = 1'b0;
                state_nxt         = ST_POP;
              end else if (high_bump_r == PMAX) begin
                out_oop_nxt = 1'b1;
              end else begin
                bud_cmd.high_take = 1'b1;
                out_page_nxt      = 16'(high_bump_r);
                high_bump_nxt     = high_bump_r + PONE;
              end
            end
            ACT_FREE_HIGH: begin
              if (!bud_stat.exceeded && page_m != PZERO) begin
                bud_cmd.high_free = 1'b1;
                ram_we            = 1'b1;
                ram_waddr         = page_m;
                ram_wdata         = high_head_r;
                high_head_nxt     = page_m;
              end
            end
            ACT_SET_LIMIT: begin
              bud_cmd.set_limit = 1'b1;
            end
            default: ;
          endcase
          out_exc_nxt = bud_stat.exceeded_nxt;
        end
      end
      ST_POP: begin
        // The output register was emptied when the item was taken.
        if (pop_high_r) begin
          high_head_nxt = ram_rdata;
        end else begin
          low_head_nxt = ram_rdata;
        end
        out_valid_nxt = 1'b1;
        out_page_nxt  = 16'(pop_page_r);
        out_exc_nxt   = bud_stat.exceeded;
        out_oop_nxt   = 1'b0;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      low_bump_r  <= LOW_RST;
      high_bump_r <= HIGH_RST;
      low_head_r  <= PZERO;
      high_head_r <= PZERO;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      low_bump_r  <= low_bump_nxt;
      high_bump_r <= high_bump_nxt;
      low_head_r  <= low_head_nxt;
      high_head_r <= high_head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pop_page_r <= pop_page_nxt;
    pop_high_r <= pop_high_nxt;
    out_page_r <= out_page_nxt;
    out_exc_r  <= out_exc_nxt;
    out_oop_r  <= out_oop_nxt;
  end

  pfla_next_ram #(
    .PAGE_BITS (PAGE_BITS)
  ) u_next_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pfla_budget u_budget (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (bud_cmd),
    .stat  (bud_stat)
  );

  assign out_valid          = out_valid_r;
  assign out_granted_page   = out_page_r;
  assign out_limit_exceeded = out_exc_r;
  assign out_out_of_pages   = out_oop_r;

endmodule

`default_nettype wire
